@@ rtl/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg
// shared types and constants for the order book matching unit
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int ORDER_SLOTS = 32;
    localparam int CNT_W = $clog2(ORDER_SLOTS + 1);

    localparam logic [3:0] ST_FILLED    = 4'd0;
    localparam logic [3:0] ST_RESTING   = 4'd1;
    localparam logic [3:0] ST_CXL_REM   = 4'd2;
    localparam logic [3:0] ST_BAD_QTY   = 4'd3;
    localparam logic [3:0] ST_DUP_ID    = 4'd4;
    localparam logic [3:0] ST_NO_BOOK   = 4'd5;
    localparam logic [3:0] ST_BOOK_FULL = 4'd6;
    localparam logic [3:0] ST_CXL_OK    = 4'd7;
    localparam logic [3:0] ST_CXL_NF    = 4'd8;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_CANCEL = 1'b1;
    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] order_id;
        logic        side;
        logic        order_type;
        logic [15:0] price;
        logic [31:0] qty;
    } lobm_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] taker_id;
        logic [31:0] maker_id;
        logic [15:0] trade_price;
        logic [31:0] fill_qty;
        logic        aggressor_side;
        logic [31:0] trade_seq;
        logic [31:0] filled_total;
        logic [31:0] left_resting;
        logic [3:0]  status;
        logic        last;
    } lobm_out_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] price;
        logic [31:0] qty;
    } lobm_entry_t;

    // command broadcast from the sequencer to every cell of one book
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_SETQ0
    } lobm_cmd_t;

    typedef struct packed {
        lobm_cmd_t   cmd;
        logic        is_bid;
        logic [31:0] key_id;
        logic [15:0] key_price;
        logic [31:0] new_qty;
    } lobm_ctl_t;

    // per-cell flags that the book combines into its chain and hit output
    typedef struct packed {
        logic id_hit;
        logic after;
    } lobm_flag_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MATCH,
        S_UPDATE,
        S_REPORT
    } lobm_state_t;

endpackage

@@ rtl/lobm_cell.sv @@
// ----------------------------------------------------------------------------
// lobm_cell
// one slot of a sorted book, shifts with its neighbors on insert and remove
// ----------------------------------------------------------------------------
module lobm_cell import lobm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lobm_ctl_t   ctl,
    input  logic        is_head,
    input  logic        valid_left,
    input  lobm_entry_t entry_left,
    input  logic        after_left,
    input  logic        valid_right,
    input  lobm_entry_t entry_right,
    output logic        valid,
    output lobm_entry_t entry,
    output lobm_flag_t  flag
);

    logic        valid_reg, valid_next;
    lobm_entry_t entry_reg, entry_next;
    logic        better;
    logic        after_here;
    logic        hit_left_or_here;

    // new order goes before this entry when its price is strictly better
    assign better = ctl.is_bid ? (ctl.key_price > entry_reg.price)
                               : (ctl.key_price < entry_reg.price);
    assign after_here = valid_reg && better;
    assign flag.after = after_here;
    assign flag.id_hit = valid_reg && (entry_reg.id == ctl.key_id);
    assign hit_left_or_here = flag.id_hit || after_left;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (ctl.cmd)
            CMD_INSERT: begin
                // the first cell that the new key beats, or the first empty one, takes the new order, rest shift right
                if (after_left) begin
                    valid_next = valid_left;
                    entry_next = entry_left;
                end else if (after_here || !valid_reg) begin
                    valid_next = 1'b1;
                    entry_next = '{id: ctl.key_id, price: ctl.key_price,
                                   qty: ctl.new_qty};
                end
            end
            CMD_REMOVE: begin
                // after_left here carries the id-hit chain
                if (hit_left_or_here) begin
                    valid_next = valid_right;
                    entry_next = entry_right;
                end
            end
            CMD_SETQ0: begin
                if (is_head) entry_next.qty = ctl.new_qty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

@@ rtl/lobm_book.sv @@
// ----------------------------------------------------------------------------
// lobm_book
// row of cells holding one side of the book, best order in cell 0
// ----------------------------------------------------------------------------
module lobm_book import lobm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  lobm_ctl_t         ctl,
    output logic              any_hit,
    output logic              full,
    output logic              empty,
    output lobm_entry_t       head
);

    logic        valid_c [ORDER_SLOTS];
    lobm_entry_t entry_c [ORDER_SLOTS];
    lobm_flag_t  flag_c  [ORDER_SLOTS];
    logic        chain   [ORDER_SLOTS+1];
    logic [ORDER_SLOTS-1:0] hit_vec;

    // chain: for insert the ripple of "better found or empty", for remove the id hit
    assign chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < ORDER_SLOTS; g++) begin : g_cell
            logic        vr;
            lobm_entry_t er;
            logic        vl;
            lobm_entry_t el;
            if (g == ORDER_SLOTS - 1) begin : g_end
                assign vr = 1'b0;
                assign er = entry_c[g];
            end else begin : g_mid
                assign vr = valid_c[g+1];
                assign er = entry_c[g+1];
            end
            if (g == 0) begin : g_first
                assign vl = 1'b0;
                assign el = entry_c[g];
            end else begin : g_rest
                assign vl = valid_c[g-1];
                assign el = entry_c[g-1];
            end
            assign chain[g+1] = chain[g] ||
                ((ctl.cmd == CMD_REMOVE) ? flag_c[g].id_hit
                                         : (flag_c[g].after || !valid_c[g]));
            assign hit_vec[g] = flag_c[g].id_hit;
            lobm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .is_head    (g == 0),
                .valid_left (vl),
                .entry_left (el),
                .after_left (chain[g]),
                .valid_right(vr),
                .entry_right(er),
                .valid      (valid_c[g]),
                .entry      (entry_c[g]),
                .flag       (flag_c[g])
            );
        end
    endgenerate

    assign any_hit = |hit_vec;
    assign full    = valid_c[ORDER_SLOTS-1];
    assign empty   = !valid_c[0];
    assign head    = entry_c[0];

endmodule

@@ rtl/limit_order_matching_engine_unit.sv @@
// ----------------------------------------------------------------------------
// limit_order_matching_engine_unit
// price-time priority order book with matching, two cell chains
// ----------------------------------------------------------------------------
//  channel | dir | payload    | handshake
//  s_      | in  | lobm_in_t  | s_valid / s_ready
//  m_      | out | lobm_out_t | m_valid / m_ready
//
//  a cancel or a rejected submit goes from S_CHECK to S_REPORT and back to S_IDLE
//  a submit that reaches matching passes S_MATCH and S_UPDATE once per fill; resting adds no state
//  the chains shift every cell together; the sequencer drives one command per cycle
//  synchronous active-low reset empties both books and clears the trade counter
//  each result beat waits in the output register until m_ready
module limit_order_matching_engine_unit import lobm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lobm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lobm_out_t m_data
);

    lobm_state_t state_reg, state_next;
    lobm_in_t    req_reg, req_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] seq_reg, seq_next;
    logic        mv_reg, mv_next;
    lobm_out_t   md_reg, md_next;
    logic        rem_reg, rem_next;
    logic [31:0] fillq_reg, fillq_next;

    lobm_ctl_t   bid_ctl, ask_ctl;
    logic        bid_hit, ask_hit, bid_full, ask_full, bid_empty, ask_empty;
    lobm_entry_t bid_head, ask_head;

    lobm_book u_bid (.aclk(aclk), .aresetn(aresetn), .ctl(bid_ctl), .any_hit(bid_hit),
                     .full(bid_full), .empty(bid_empty), .head(bid_head));
    lobm_book u_ask (.aclk(aclk), .aresetn(aresetn), .ctl(ask_ctl), .any_hit(ask_hit),
                     .full(ask_full), .empty(ask_empty), .head(ask_head));

    logic        opp_empty, own_full, crosses;
    lobm_entry_t opp_head;
    logic        out_free;
    lobm_out_t   rpt;
    logic [31:0] fill;

    assign opp_empty = req_reg.side ? bid_empty : ask_empty;
    assign opp_head  = req_reg.side ? bid_head  : ask_head;
    assign own_full  = req_reg.side ? ask_full  : bid_full;
    assign crosses   = req_reg.order_type ||
                       (req_reg.side ? (opp_head.price >= req_reg.price)
                                     : (opp_head.price <= req_reg.price));
    assign fill      = (left_reg < opp_head.qty) ? left_reg : opp_head.qty;
    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            seq_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            seq_reg   <= seq_next;
        end
        req_reg   <= req_next;
        left_reg  <= left_next;
        md_reg    <= md_next;
        rem_reg   <= rem_next;
        fillq_reg <= fillq_next;
    end

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        left_next  = left_reg;
        seq_next   = seq_reg;
        rem_next   = rem_reg;
        fillq_next = fillq_reg;
        mv_next    = mv_reg && !m_ready;
        md_next    = md_reg;
        bid_ctl    = '{cmd: CMD_HOLD, is_bid: 1'b1, key_id: req_reg.order_id,
                       key_price: req_reg.price, new_qty: left_reg};
        ask_ctl    = '{cmd: CMD_HOLD, is_bid: 1'b0, key_id: req_reg.order_id,
                       key_price: req_reg.price, new_qty: left_reg};
        rpt = '0;
        rpt.kind = KIND_REPORT;
        rpt.last = 1'b1;
        rpt.taker_id = req_reg.order_id;
        rpt.aggressor_side = (req_reg.opcode == OP_CANCEL) ? 1'b0 : req_reg.side;
        rpt.filled_total = req_reg.qty - left_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    left_next  = s_data.qty;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    state_next = S_REPORT;
                    if (req_reg.opcode == OP_CANCEL) begin
                        rpt.status = (bid_hit || ask_hit) ? ST_CXL_OK : ST_CXL_NF;
                        if (bid_hit) bid_ctl.cmd = CMD_REMOVE;
                        else if (ask_hit) ask_ctl.cmd = CMD_REMOVE;
                        rpt.filled_total = '0;
                    end else if (req_reg.qty == '0) begin
                        rpt.status = ST_BAD_QTY;
                    end else if (bid_hit || ask_hit) begin
                        rpt.status = ST_DUP_ID;
                        rpt.filled_total = '0;
                    end else if (req_reg.order_type && opp_empty) begin
                        rpt.status = ST_NO_BOOK;
                    end else begin
                        state_next = S_MATCH;
                    end
                    if (state_next == S_REPORT) begin
                        mv_next = 1'b1;
                        md_next = rpt;
                    end
                end
            end
            S_MATCH: begin
                if (out_free) begin
                    if (left_reg != '0 && !opp_empty && crosses) begin
                        md_next = '0;
                        md_next.kind = KIND_TRADE;
                        md_next.taker_id = req_reg.order_id;
                        md_next.maker_id = opp_head.id;
                        md_next.trade_price = opp_head.price;
                        md_next.fill_qty = fill;
                        md_next.aggressor_side = req_reg.side;
                        md_next.trade_seq = seq_reg + 32'd1;
                        seq_next   = seq_reg + 32'd1;
                        mv_next    = 1'b1;
                        left_next  = left_reg - fill;
                        rem_next   = (fill == opp_head.qty);
                        fillq_next = opp_head.qty - fill;
                        state_next = S_UPDATE;
                    end else begin
                        mv_next = 1'b1;
                        state_next = S_REPORT;
                        if (left_reg == '0) begin
                            rpt.status = ST_FILLED;
                        end else if (req_reg.order_type) begin
                            rpt.status = ST_CXL_REM;
                        end else if (own_full) begin
                            rpt.status = ST_BOOK_FULL;
                        end else begin
                            rpt.status = ST_RESTING;
                            rpt.left_resting = left_reg;
                            if (req_reg.side) ask_ctl.cmd = CMD_INSERT;
                            else bid_ctl.cmd = CMD_INSERT;
                        end
                        md_next = rpt;
                    end
                end
            end
            S_UPDATE: begin
                // head gets removed when drained, otherwise its quantity shrinks
                if (req_reg.side) begin
                    bid_ctl.cmd = rem_reg ? CMD_REMOVE : CMD_SETQ0;
                    bid_ctl.key_id = opp_head.id;
                    bid_ctl.new_qty = fillq_reg;
                end else begin
                    ask_ctl.cmd = rem_reg ? CMD_REMOVE : CMD_SETQ0;
                    ask_ctl.key_id = opp_head.id;
                    ask_ctl.new_qty = fillq_reg;
                end
                state_next = S_MATCH;
            end
            S_REPORT: begin
                if (!mv_reg || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

endmodule

@@ rtl/lobm_checker.sv @@
// ----------------------------------------------------------------------------
// lobm_checker
// port-level checks on the matching unit
// ----------------------------------------------------------------------------
module lobm_checker import lobm_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input lobm_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input lobm_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == m_data.kind))
        else $error("last flag differs from kind");

    a_trade_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_TRADE |-> m_data.fill_qty != '0 &&
        m_data.status == ST_FILLED)
        else $error("bad trade beat");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid |-> !$isunknown(s_data))
        else $error("input beat carries unknown bits");

endmodule

bind limit_order_matching_engine_unit lobm_checker u_lobm_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// order book matching unit: a directed table, a book-full run, then random orders and
// cancels, each result beat compared with a book model kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
    import lobm_pkg::*;

    localparam int N_RANDOM    = 300;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        lobm_in_t  beat;
        logic      has_exp;
        lobm_out_t exp;
    } dir_row_t;

    typedef struct {
        logic [31:0] id;
        logic [15:0] price;
        logic [31:0] qty;
    } resting_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lobm_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lobm_out_t m_data;

    resting_t  bids[$];
    resting_t  asks[$];
    logic [31:0] trade_count;
    lobm_out_t pending_results[$];
    int        n_errors = 0;
    int        cycles = 0;
    bit        quiet_tail = 0;
    bit        sink_stall = 0;
    int        sink_burst = 0;
    logic [31:0] used_ids[$];
    dir_row_t  dir_rows[$];

    limit_order_matching_engine_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic lobm_out_t mk_report(logic [31:0] id, logic sd, logic [31:0] filled,
                                            logic [31:0] left, logic [3:0] st);
        lobm_out_t r;
        r = '0;
        r.kind = KIND_REPORT;
        r.taker_id = id;
        r.aggressor_side = sd;
        r.filled_total = filled;
        r.left_resting = left;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int find_in(ref resting_t book[$], input logic [31:0] id);
        for (int i = 0; i < book.size(); i++)
            if (book[i].id == id) return i;
        return -1;
    endfunction

    function automatic void queue_result(lobm_out_t r);
        pending_results = {pending_results, r};
    endfunction

    // walk the opposite book and queue trades plus the closing report
    function automatic void book_predict(lobm_in_t b);
        int p;
        int k;
        logic [31:0] left;
        logic crosses;
        logic [31:0] fill;
        lobm_out_t t;
        resting_t e;
        if (b.opcode == OP_CANCEL) begin
            p = find_in(bids, b.order_id);
            if (p >= 0) bids.delete(p);
            else begin
                p = find_in(asks, b.order_id);
                if (p >= 0) asks.delete(p);
            end
            queue_result(mk_report(b.order_id, 1'b0, 0, 0,
                                   p >= 0 ? ST_CXL_OK : ST_CXL_NF));
            return;
        end
        if (b.qty == 0) begin
            queue_result(mk_report(b.order_id, b.side, 0, 0, ST_BAD_QTY));
            return;
        end
        if (find_in(bids, b.order_id) >= 0 || find_in(asks, b.order_id) >= 0) begin
            queue_result(mk_report(b.order_id, b.side, 0, 0, ST_DUP_ID));
            return;
        end
        if (b.order_type && (b.side ? bids.size() : asks.size()) == 0) begin
            queue_result(mk_report(b.order_id, b.side, 0, 0, ST_NO_BOOK));
            return;
        end
        left = b.qty;
        while (left > 0 && (b.side ? bids.size() : asks.size()) > 0) begin
            e = b.side ? bids[0] : asks[0];
            crosses = b.side ? (e.price >= b.price) : (e.price <= b.price);
            if (!b.order_type && !crosses) break;
            fill = left < e.qty ? left : e.qty;
            e.qty -= fill;
            left -= fill;
            trade_count += 1;
            t = '0;
            t.kind = KIND_TRADE;
            t.taker_id = b.order_id;
            t.maker_id = e.id;
            t.trade_price = e.price;
            t.fill_qty = fill;
            t.aggressor_side = b.side;
            t.trade_seq = trade_count;
            queue_result(t);
            if (b.side) begin
                if (e.qty == 0) void'(bids.pop_front()); else bids[0] = e;
            end else begin
                if (e.qty == 0) void'(asks.pop_front()); else asks[0] = e;
            end
        end
        if (left == 0) begin
            queue_result(mk_report(b.order_id, b.side, b.qty, 0, ST_FILLED));
        end else if (b.order_type) begin
            queue_result(mk_report(b.order_id, b.side, b.qty - left, 0, ST_CXL_REM));
        end else if ((b.side ? asks.size() : bids.size()) >= ORDER_SLOTS) begin
            queue_result(mk_report(b.order_id, b.side, b.qty - left, 0, ST_BOOK_FULL));
        end else begin
            e.id = b.order_id;
            e.price = b.price;
            e.qty = left;
            if (b.side) begin
                k = 0;
                while (k < asks.size() && !(b.price < asks[k].price)) k++;
                asks.insert(k, e);
            end else begin
                k = 0;
                while (k < bids.size() && !(b.price > bids[k].price)) k++;
                bids.insert(k, e);
            end
            queue_result(mk_report(b.order_id, b.side, b.qty - left, left, ST_RESTING));
        end
    endfunction

    // result side: random stall bursts, none in the tail
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected, taker_id %0h", m_data.taker_id);
                n_errors++;
            end else begin
                lobm_out_t x;
                x = pending_results.pop_front();
                if (m_data.kind !== x.kind) begin
                    $error("kind exp %0h got %0h", x.kind, m_data.kind); n_errors++; end
                if (m_data.taker_id !== x.taker_id) begin
                    $error("taker_id exp %0h got %0h", x.taker_id, m_data.taker_id);
                    n_errors++; end
                if (m_data.maker_id !== x.maker_id) begin
                    $error("maker_id exp %0h got %0h", x.maker_id, m_data.maker_id);
                    n_errors++; end
                if (m_data.trade_price !== x.trade_price) begin
                    $error("trade_price exp %0h got %0h", x.trade_price, m_data.trade_price);
                    n_errors++; end
                if (m_data.fill_qty !== x.fill_qty) begin
                    $error("fill_qty exp %0h got %0h", x.fill_qty, m_data.fill_qty);
                    n_errors++; end
                if (m_data.aggressor_side !== x.aggressor_side) begin
                    $error("aggressor_side exp %0h got %0h", x.aggressor_side,
                           m_data.aggressor_side);
                    n_errors++; end
                if (m_data.trade_seq !== x.trade_seq) begin
                    $error("trade_seq exp %0h got %0h", x.trade_seq, m_data.trade_seq);
                    n_errors++; end
                if (m_data.filled_total !== x.filled_total) begin
                    $error("filled_total exp %0h got %0h", x.filled_total,
                           m_data.filled_total);
                    n_errors++; end
                if (m_data.left_resting !== x.left_resting) begin
                    $error("left_resting exp %0h got %0h", x.left_resting,
                           m_data.left_resting);
                    n_errors++; end
                if (m_data.status !== x.status) begin
                    $error("status exp %0h got %0h", x.status, m_data.status); n_errors++; end
                if (m_data.last !== x.last) begin
                    $error("last exp %0h got %0h", x.last, m_data.last); n_errors++; end
            end
        end
        if (!aresetn || quiet_tail) begin
            m_ready <= aresetn;
        end else if (sink_burst > 0) begin
            sink_burst <= sink_burst - 1;
            m_ready <= !sink_stall;
        end else begin
            sink_stall <= ($urandom_range(0, 2) == 0);
            sink_burst <= $urandom_range(1, 8);
            m_ready <= 1'b1;
        end
    end

    // one beat: optional idle burst first, then hold valid until accepted
    task automatic send_beat(lobm_in_t b);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book_predict(b);
    endtask

    function automatic lobm_in_t mk_order(logic op, logic [31:0] id, logic sd, logic mkt,
                                          logic [15:0] px, logic [31:0] q);
        lobm_in_t b;
        b.opcode = op;
        b.order_id = id;
        b.side = sd;
        b.order_type = mkt;
        b.price = px;
        b.qty = q;
        return b;
    endfunction

    function automatic void add_row(lobm_in_t b, logic has, lobm_out_t x);
        dir_row_t r;
        r.beat = b;
        r.has_exp = has;
        r.exp = x;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic logic [31:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 1) == 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return $urandom_range(1, 200);
    endfunction

    initial begin
        lobm_in_t b;
        lobm_out_t none;
        none = '0;
        trade_count = '0;

        // typed-in rows: rejects and cancels on an empty book, then resting, crossing and cancelled orders
        add_row(mk_order(OP_CANCEL, 32'h5, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                mk_report(32'h5, 1'b0, 0, 0, ST_CXL_NF));
        add_row(mk_order(OP_SUBMIT, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h10, 32'h0), 1'b1,
                mk_report(32'hFFFF_FFFF, 1'b1, 0, 0, ST_BAD_QTY));
        add_row(mk_order(OP_SUBMIT, 32'h7, 1'b0, 1'b1, 16'h0, 32'h10), 1'b1,
                mk_report(32'h7, 1'b0, 0, 0, ST_NO_BOOK));
        add_row(mk_order(OP_SUBMIT, 32'h1, 1'b0, 1'b0, 16'h0, 32'hFFFF_FFFF), 1'b1,
                mk_report(32'h1, 1'b0, 0, 32'hFFFF_FFFF, ST_RESTING));
        add_row(mk_order(OP_SUBMIT, 32'h1, 1'b1, 1'b0, 16'h5, 32'h3), 1'b1,
                mk_report(32'h1, 1'b1, 0, 0, ST_DUP_ID));
        add_row(mk_order(OP_SUBMIT, 32'h2, 1'b0, 1'b0, 16'hFFFF, 32'h4), 1'b1,
                mk_report(32'h2, 1'b0, 0, 32'h4, ST_RESTING));
        add_row(mk_order(OP_SUBMIT, 32'h3, 1'b0, 1'b0, 16'hFFFF, 32'h6), 1'b0, none);
        add_row(mk_order(OP_SUBMIT, 32'h0, 1'b1, 1'b0, 16'h10, 32'h20), 1'b0, none);
        add_row(mk_order(OP_SUBMIT, 32'h4, 1'b1, 1'b1, 16'hFFFF, 32'h8), 1'b0, none);
        add_row(mk_order(OP_SUBMIT, 32'h8, 1'b0, 1'b0, 16'h20, 32'h30), 1'b0, none);
        add_row(mk_order(OP_SUBMIT, 32'h9, 1'b0, 1'b1, 16'h0, 32'hFFFF_FFFF), 1'b0, none);
        add_row(mk_order(OP_SUBMIT, 32'hA, 1'b1, 1'b0, 16'h30, 32'h5), 1'b0, none);
        add_row(mk_order(OP_CANCEL, 32'hA, 1'b0, 1'b0, 16'h0, 32'h0), 1'b1,
                mk_report(32'hA, 1'b0, 0, 0, ST_CXL_OK));
        add_row(mk_order(OP_CANCEL, 32'h1, 1'b0, 1'b0, 16'h0, 32'h0), 1'b0, none);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].beat);
            if (dir_rows[i].has_exp && pending_results[$] !== dir_rows[i].exp) begin
                $error("table row %0d: expected report differs from book model", i);
                n_errors++;
            end
        end

        // fill the bid book to capacity and overflow it, then cross it
        for (int i = 0; i < ORDER_SLOTS + 1; i++)
            send_beat(mk_order(OP_SUBMIT, 32'h1000 + i, 1'b0, 1'b0,
                               16'(16'h100 + i % 4), 32'h1));
        send_beat(mk_order(OP_SUBMIT, 32'h2000, 1'b1, 1'b0, 16'h103, 32'h2));
        send_beat(mk_order(OP_SUBMIT, 32'h2001, 1'b0, 1'b0, 16'h80, 32'h1));
        send_beat(mk_order(OP_SUBMIT, 32'h2002, 1'b0, 1'b0, 16'h80, 32'h1));
        send_beat(mk_order(OP_SUBMIT, 32'h2003, 1'b1, 1'b1, 16'h0, 32'hFFFF_FFFF));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 40) quiet_tail = 1;
            b = mk_order($urandom_range(0, 4) == 0, pick_id(), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 5) == 0, 16'(1000 + $urandom_range(0, 12)),
                         $urandom_range(1, 40));
            if ($urandom_range(0, 15) == 0) b.price = 16'($urandom);
            if ($urandom_range(0, 15) == 0) b.qty = $urandom;
            if ($urandom_range(0, 25) == 0) b.qty = 0;
            if ($urandom_range(0, 15) == 0) b.order_id = $urandom;
            if (b.opcode == OP_SUBMIT) used_ids.insert(used_ids.size(), b.order_id);
            send_beat(b);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
